>>> hdl/stcc_pkg.sv
// ----------------------------------------------------------------------------
// stcc_pkg
// Shared types and constants for the strided transfer contiguity checker.
// ----------------------------------------------------------------------------
package stcc_pkg;

    // field widths
    localparam int DATA_W     = 48;
    localparam int PROD_W     = 63;
    localparam int LVL_W      = 4;
    localparam int STEP_W     = $clog2(DATA_W);
    localparam int QUEUE_AW   = 1;

    // supported stride levels per descriptor
    localparam logic [LVL_W-1:0] MAX_LEVELS = LVL_W'(7);

    // largest signed 64-bit value, used as saturation level
    localparam logic [PROD_W-1:0] MAX_SIGNED = {PROD_W{1'b1}};

    // item kinds decided by the front end
    localparam logic [1:0] KIND_STRIDE = 2'd0;
    localparam logic [1:0] KIND_EXCESS = 2'd1;
    localparam logic [1:0] KIND_LAST   = 2'd2;

    // input transaction
    typedef struct packed {
        logic [DATA_W-1:0] source_stride;
        logic [DATA_W-1:0] dest_stride;
        logic [DATA_W-1:0] level_count;
        logic              is_last;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic              contiguous;
        logic [PROD_W-1:0] total_bytes;
        logic              product_overflow;
        logic              too_many_levels;
    } t_out_item;

    // classified item travelling through the queue
    typedef struct packed {
        logic [1:0]        kind;
        logic              first_level;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] dst;
        logic [DATA_W-1:0] cnt;
    } t_entry;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // operands loaded into the arithmetic lanes
    typedef struct packed {
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] dst;
        logic [DATA_W-1:0] div_src;
        logic [DATA_W-1:0] div_dst;
        logic [DATA_W-1:0] cnt;
        logic [PROD_W-1:0] bytes;
        logic [PROD_W-1:0] span;
    } t_arith_ops;

    // lane control from the back end sequencer
    typedef struct packed {
        logic start;
        logic step;
    } t_arith_ctl;

    // lane results after a full pass
    typedef struct packed {
        logic [PROD_W-1:0] bytes_prod;
        logic              bytes_ovf;
        logic [PROD_W-1:0] span_prod;
        logic              span_ovf;
        logic [DATA_W-1:0] q_src;
        logic [DATA_W-1:0] q_dst;
    } t_arith_res;

    // back end status seen at the top level
    typedef struct packed {
        logic busy;
        logic result_load;
    } t_back_status;

endpackage

>>> hdl/strided_transfer_contiguity_check_core.sv
// ----------------------------------------------------------------------------
// strided_transfer_contiguity_check_core
// Classifies a strided DMA descriptor, one stride level per transaction,
// and reports contiguity, byte product and overflow on the final count.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------
//   in      | input     | i_in_valid/o_in_stall | t_in_item
//   out     | output    | o_out_valid/i_out_stall | t_out_item
//
// in the back end each transaction is issued from idle, then takes 48 steps
// of the serial multiply and divide lanes and a commit state, one at a time
// the front end and a two-entry queue take transactions while the back
// end works; the input stalls only when the queue is full
// a final count holds in commit while the output register is full and stalled
// reset is synchronous, active low, and returns to an empty descriptor
// ----------------------------------------------------------------------------
module strided_transfer_contiguity_check_core
    import stcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_entry       front_entry;
    t_entry       q_head;
    t_q_status    q_status;
    t_back_status back_status;
    logic         push;
    logic         pop;

    // front end: accept and classify
    stcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    // decoupling queue
    stcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back end: serial arithmetic and verdict
    stcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (q_head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (back_status)
    );

    // no push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // no pop from an empty queue, and only when the back end is free
    a_pop_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!q_status.empty && !back_status.busy))
        else $error("illegal queue pop");

    // a result is only written when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.result_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrites pending transaction");

    // a written result shows up on the next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.result_load |=> o_out_valid)
        else $error("result not presented");

endmodule

>>> hdl/stcc_front.sv
// ----------------------------------------------------------------------------
// stcc_front
// Accepts input transactions, tracks the stride level count and tags each
// item as stride level, excess level or final count.
// ----------------------------------------------------------------------------
module stcc_front
    import stcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_entry    o_entry
);

    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic             excess;

    // accept whenever the queue has room
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;
    assign excess     = (r_level >= MAX_LEVELS);

    // classify the item
    always_comb begin
        o_entry.src         = i_in_data.source_stride;
        o_entry.dst         = i_in_data.dest_stride;
        o_entry.cnt         = i_in_data.level_count;
        o_entry.first_level = (r_level == '0);
        priority if (i_in_data.is_last) begin
            o_entry.kind = KIND_LAST;
        end else if (excess) begin
            o_entry.kind = KIND_EXCESS;
        end else begin
            o_entry.kind = KIND_STRIDE;
        end
    end

    // level counter, cleared by the final count
    always_comb begin
        n_level = r_level;
        if (o_push) begin
            priority if (i_in_data.is_last) begin
                n_level = '0;
            end else if (!excess) begin
                n_level = r_level + LVL_W'(1);
            end else begin
                // excess levels leave the count at its limit
                n_level = r_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

endmodule

>>> hdl/stcc_queue.sv
// ----------------------------------------------------------------------------
// stcc_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module stcc_queue
    import stcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int DEPTH = 2 ** QUEUE_AW;

    t_entry              r_mem [DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (QUEUE_AW+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/stcc_arith.sv
// ----------------------------------------------------------------------------
// stcc_arith
// Serial arithmetic lanes: two checked shift-add multipliers sharing the
// count as multiplier, and two restoring dividers, one bit per step.
// ----------------------------------------------------------------------------
module stcc_arith
    import stcc_pkg::*;
(
    input  logic       i_clk,
    input  t_arith_ctl i_ctl,
    input  t_arith_ops i_ops,
    output t_arith_res o_res
);

    logic [DATA_W-1:0] r_mbits;
    logic [PROD_W-1:0] r_ma_b;
    logic [PROD_W-1:0] r_ma_s;
    logic [PROD_W-1:0] r_acc_b;
    logic [PROD_W-1:0] r_acc_s;
    logic              r_ovf_b;
    logic              r_ovf_s;
    logic [DATA_W-1:0] r_dvd_s;
    logic [DATA_W-1:0] r_dvd_d;
    logic [DATA_W-1:0] r_rem_s;
    logic [DATA_W-1:0] r_rem_d;
    logic [DATA_W-1:0] r_dsr_s;
    logic [DATA_W-1:0] r_dsr_d;

    logic [PROD_W+1:0] sum_b;
    logic [PROD_W+1:0] sum_s;
    logic [DATA_W:0]   sh_s;
    logic [DATA_W:0]   sh_d;
    logic [DATA_W:0]   diff_s;
    logic [DATA_W:0]   diff_d;
    logic              ge_s;
    logic              ge_d;

    // multiplier step, msb of count first: acc = 2*acc + bit*a
    assign sum_b = {1'b0, r_acc_b, 1'b0} + {2'b00, (r_mbits[DATA_W-1] ? r_ma_b : '0)};
    assign sum_s = {1'b0, r_acc_s, 1'b0} + {2'b00, (r_mbits[DATA_W-1] ? r_ma_s : '0)};

    // divider step, restoring
    assign sh_s   = {r_rem_s, r_dvd_s[DATA_W-1]};
    assign sh_d   = {r_rem_d, r_dvd_d[DATA_W-1]};
    assign ge_s   = (sh_s >= {1'b0, r_dsr_s});
    assign ge_d   = (sh_d >= {1'b0, r_dsr_d});
    assign diff_s = sh_s - {1'b0, r_dsr_s};
    assign diff_d = sh_d - {1'b0, r_dsr_d};

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mbits <= i_ops.cnt;
            r_ma_b  <= i_ops.bytes;
            r_ma_s  <= i_ops.span;
            r_acc_b <= '0;
            r_acc_s <= '0;
            r_ovf_b <= 1'b0;
            r_ovf_s <= 1'b0;
            r_dvd_s <= i_ops.src;
            r_dvd_d <= i_ops.dst;
            r_rem_s <= '0;
            r_rem_d <= '0;
            r_dsr_s <= i_ops.div_src;
            r_dsr_d <= i_ops.div_dst;
        end else if (i_ctl.step) begin
            r_mbits <= {r_mbits[DATA_W-2:0], 1'b0};
            // once the partial product passes 2^63-1 the result can only grow
            r_acc_b <= sum_b[PROD_W-1:0];
            r_acc_s <= sum_s[PROD_W-1:0];
            r_ovf_b <= r_ovf_b || (sum_b[PROD_W+1:PROD_W] != 2'b00);
            r_ovf_s <= r_ovf_s || (sum_s[PROD_W+1:PROD_W] != 2'b00);
            r_rem_s <= ge_s ? diff_s[DATA_W-1:0] : sh_s[DATA_W-1:0];
            r_rem_d <= ge_d ? diff_d[DATA_W-1:0] : sh_d[DATA_W-1:0];
            r_dvd_s <= {r_dvd_s[DATA_W-2:0], ge_s};
            r_dvd_d <= {r_dvd_d[DATA_W-2:0], ge_d};
        end
    end

    assign o_res.bytes_prod = r_acc_b;
    assign o_res.bytes_ovf  = r_ovf_b;
    assign o_res.span_prod  = r_acc_s;
    assign o_res.span_ovf   = r_ovf_s;
    assign o_res.q_src      = r_dvd_s;
    assign o_res.q_dst      = r_dvd_d;

endmodule

>>> hdl/stcc_back.sv
// ----------------------------------------------------------------------------
// stcc_back
// Back end: pops classified items, runs them through the serial lanes,
// updates the descriptor state and emits the verdict on the final count.
// ----------------------------------------------------------------------------
module stcc_back
    import stcc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_entry       i_q_head,
    input  t_q_status    i_q_status,
    output logic         o_pop,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output t_out_item    o_out_data,
    output t_back_status o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [STEP_W-1:0] r_step;
    t_entry            r_item;

    // descriptor state
    logic [DATA_W-1:0] r_prev_src, n_prev_src;
    logic [DATA_W-1:0] r_prev_dst, n_prev_dst;
    logic [PROD_W-1:0] r_span, n_span;
    logic [PROD_W-1:0] r_bytes, n_bytes;
    logic              r_gap, n_gap;
    logic              r_sc, n_sc;
    logic              r_ovf, n_ovf;
    logic              r_exc, n_exc;

    logic              r_out_valid;
    t_out_item         r_out_data;
    t_out_item         n_out_data;

    t_arith_ctl        ctl;
    t_arith_ops        ops;
    t_arith_res        res;

    logic              apply;
    logic              load_out;
    logic              zdiv;
    logic              sc_div;
    logic [DATA_W-1:0] ld_src;
    logic [DATA_W-1:0] ld_dst;
    logic              short_level;
    logic              sc_fin;

    // lane start and stepping
    assign o_pop     = (r_state == S_IDLE) && !i_q_status.empty;
    assign ctl.start = o_pop;
    assign ctl.step  = (r_state == S_RUN);

    assign ops.src     = i_q_head.src;
    assign ops.dst     = i_q_head.dst;
    assign ops.div_src = r_prev_src;
    assign ops.div_dst = r_prev_dst;
    assign ops.cnt     = i_q_head.cnt;
    assign ops.bytes   = r_bytes;
    assign ops.span    = r_span;

    stcc_arith u_arith (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_ops (ops),
        .o_res (res)
    );

    // commit waits only when a final count meets a full, stalled output
    assign apply = (r_state == S_DONE) &&
                   !((r_item.kind == KIND_LAST) && r_out_valid && i_out_stall);
    assign load_out = apply && (r_item.kind == KIND_LAST);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_pop) begin
                n_state = S_RUN;
            end
            S_RUN: if (r_step == STEP_W'(DATA_W - 1)) begin
                n_state = S_DONE;
            end
            S_DONE: if (apply) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // leading dimensions and level checks
    assign zdiv   = !r_item.first_level && ((r_prev_src == '0) || (r_prev_dst == '0));
    assign sc_div = r_sc && !zdiv;
    assign ld_src = r_item.first_level ? r_item.src : res.q_src;
    assign ld_dst = r_item.first_level ? r_item.dst : res.q_dst;
    assign short_level = (r_item.cnt < ld_src) || (r_item.cnt < ld_dst);
    assign sc_fin = r_sc && !(r_gap && !r_item.first_level &&
                              (r_item.cnt != DATA_W'(1)));

    // state update at commit
    always_comb begin
        n_prev_src = r_prev_src;
        n_prev_dst = r_prev_dst;
        n_span     = r_span;
        n_bytes    = r_bytes;
        n_gap      = r_gap;
        n_sc       = r_sc;
        n_ovf      = r_ovf;
        n_exc      = r_exc;
        n_out_data = r_out_data;

        // saturating byte product
        if (!r_ovf) begin
            if (res.bytes_ovf) begin
                n_ovf   = 1'b1;
                n_bytes = MAX_SIGNED;
            end else begin
                n_bytes = res.bytes_prod;
            end
        end

        unique case (r_item.kind)
            KIND_STRIDE: begin
                n_prev_src = r_item.src;
                n_prev_dst = r_item.dst;
                n_sc       = sc_div;
                if (sc_div) begin
                    priority if (res.span_ovf) begin
                        n_sc = 1'b0;
                    end else begin
                        n_span = res.span_prod;
                        priority if (short_level && r_gap) begin
                            n_sc = 1'b0;
                        end else if (short_level) begin
                            n_gap = 1'b1;
                        end else if ((r_item.cnt != DATA_W'(1)) && r_gap) begin
                            n_sc = 1'b0;
                        end else begin
                            // full level, gap flag unchanged
                            n_gap = r_gap;
                        end
                    end
                end
            end
            KIND_EXCESS: begin
                n_exc = 1'b1;
                n_sc  = 1'b0;
            end
            KIND_LAST: begin
                n_out_data.contiguous       = sc_fin;
                n_out_data.total_bytes      = n_bytes;
                n_out_data.product_overflow = n_ovf;
                n_out_data.too_many_levels  = r_exc;
                // back to the idle descriptor state
                n_prev_src = '0;
                n_prev_dst = '0;
                n_span     = PROD_W'(1);
                n_bytes    = PROD_W'(1);
                n_gap      = 1'b0;
                n_sc       = 1'b1;
                n_ovf      = 1'b0;
                n_exc      = 1'b0;
            end
            default: begin
                n_sc = r_sc;
            end
        endcase
    end

    // control and descriptor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_prev_src  <= '0;
            r_prev_dst  <= '0;
            r_span      <= PROD_W'(1);
            r_bytes     <= PROD_W'(1);
            r_gap       <= 1'b0;
            r_sc        <= 1'b1;
            r_ovf       <= 1'b0;
            r_exc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == S_RUN) ? r_step + STEP_W'(1) : '0;
            if (apply) begin
                r_prev_src <= n_prev_src;
                r_prev_dst <= n_prev_dst;
                r_span     <= n_span;
                r_bytes    <= n_bytes;
                r_gap      <= n_gap;
                r_sc       <= n_sc;
                r_ovf      <= n_ovf;
                r_exc      <= n_exc;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_head;
        end
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;
    assign o_status.busy        = (r_state != S_IDLE);
    assign o_status.result_load = load_out;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strided transfer contiguity checker. Descriptors
// go in as stride-level transactions closed by a final count. A scoreboard
// class keeps its own copy of the descriptor state, works out the verdict of
// each descriptor and compares it field by field with the output transactions.
// Stimulus is a directed set of corner descriptors and then random
// descriptors, mostly well-formed, under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import stcc_pkg::*;

    // verdict tracker: mirrors the descriptor state and queues expected results
    class contiguity_scoreboard;
        localparam logic [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;

        logic [LVL_W-1:0]  levels_seen;
        logic [DATA_W-1:0] prev_src;
        logic [DATA_W-1:0] prev_dst;
        logic [63:0]       span;
        logic [63:0]       bytes;
        logic              gap;
        logic              contig;
        logic              ovf;
        logic              excess;
        t_out_item         verdicts_due[$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
            clear();
        endfunction

        // empty descriptor
        function void clear();
            levels_seen = '0;
            prev_src    = '0;
            prev_dst    = '0;
            span        = 64'd1;
            bytes       = 64'd1;
            gap         = 1'b0;
            contig      = 1'b1;
            ovf         = 1'b0;
            excess      = 1'b0;
        endfunction

        // true when a * b would leave the signed 64-bit range
        function bit exceeds(logic [63:0] a, logic [63:0] b);
            return (a != 0) && (b != 0) && (a > SAT64 / b);
        endfunction

        // one stride level: leading dimensions, span and gap tracking
        function void stride_level(logic [DATA_W-1:0] src, logic [DATA_W-1:0] dst,
                                   logic [DATA_W-1:0] cnt);
            logic [DATA_W-1:0] ld_src;
            logic [DATA_W-1:0] ld_dst;
            logic              short_lvl;
            if (levels_seen == 0) begin
                ld_src = src;
                ld_dst = dst;
            end else if (prev_src == 0 || prev_dst == 0) begin
                contig = 1'b0;
                ld_src = '0;
                ld_dst = '0;
            end else begin
                ld_src = src / prev_src;
                ld_dst = dst / prev_dst;
            end
            prev_src = src;
            prev_dst = dst;
            if (!contig) return;
            if (exceeds(span, 64'(cnt))) begin
                contig = 1'b0;
                return;
            end
            span = span * 64'(cnt);
            short_lvl = (cnt < ld_src) || (cnt < ld_dst);
            if (short_lvl && gap) contig = 1'b0;
            else if (short_lvl) gap = 1'b1;
            else if (cnt != 1 && gap) contig = 1'b0;
        endfunction

        // accepted input transaction
        function void note_input(t_in_item it);
            t_out_item verdict;
            // saturating byte product over every count
            if (!ovf) begin
                if (exceeds(bytes, 64'(it.level_count))) begin
                    ovf   = 1'b1;
                    bytes = SAT64;
                end else begin
                    bytes = bytes * 64'(it.level_count);
                end
            end
            if (!it.is_last) begin
                if (levels_seen >= MAX_LEVELS) begin
                    excess = 1'b1;
                    contig = 1'b0;
                end else begin
                    stride_level(it.source_stride, it.dest_stride, it.level_count);
                    levels_seen = levels_seen + 1'b1;
                end
                return;
            end
            // final count closes the descriptor
            if (gap && contig && levels_seen > 0 && it.level_count != 1) contig = 1'b0;
            verdict.contiguous       = contig;
            verdict.total_bytes      = bytes[PROD_W-1:0];
            verdict.product_overflow = ovf;
            verdict.too_many_levels  = excess;
            verdicts_due.push_back(verdict);
            clear();
        endfunction

        // accepted output transaction against the oldest expected verdict
        function void check_result(t_out_item got);
            t_out_item want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatch_count++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.contiguous !== want.contiguous) begin
                $display("%0t: contiguous expected %0b actual %0b",
                         $time, want.contiguous, got.contiguous);
                mismatch_count++;
            end
            if (got.total_bytes !== want.total_bytes) begin
                $display("%0t: total_bytes expected %0h actual %0h",
                         $time, want.total_bytes, got.total_bytes);
                mismatch_count++;
            end
            if (got.product_overflow !== want.product_overflow) begin
                $display("%0t: product_overflow expected %0b actual %0b",
                         $time, want.product_overflow, got.product_overflow);
                mismatch_count++;
            end
            if (got.too_many_levels !== want.too_many_levels) begin
                $display("%0t: too_many_levels expected %0b actual %0b",
                         $time, want.too_many_levels, got.too_many_levels);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_data    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int send_idle_pct = 6;
    int recv_stall_pct = 71;
    int items_sent = 0;

    contiguity_scoreboard sb = new();

    strided_transfer_contiguity_check_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // random receiver back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) sb.note_input(in_data);
            if (o_out_valid && !out_stall) sb.check_result(o_out_data);
        end
    end

    // run limit
    initial begin
        #(12 * 1000000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [DATA_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[DATA_W-1:0];
    endfunction

    function automatic t_in_item level_item(logic [DATA_W-1:0] src,
                                            logic [DATA_W-1:0] dst,
                                            logic [DATA_W-1:0] cnt);
        t_in_item it;
        it.source_stride = src;
        it.dest_stride   = dst;
        it.level_count   = cnt;
        it.is_last       = 1'b0;
        return it;
    endfunction

    // strides are don't-care on the final count, so fill them with noise
    function automatic t_in_item final_item(logic [DATA_W-1:0] cnt);
        t_in_item it;
        it.source_stride = rand48();
        it.dest_stride   = rand48();
        it.level_count   = cnt;
        it.is_last       = 1'b1;
        return it;
    endfunction

    // counts: mostly small, with zero, unit, large and full-width values
    function automatic logic [DATA_W-1:0] pick_count();
        case ($urandom_range(19))
            0:       return '0;
            1:       return rand48();
            2:       return {DATA_W{1'b1}};
            3, 4, 5: return 48'd1;
            6:       return 48'($urandom_range(1 << 24, 1 << 16));
            default: return 48'($urandom_range(9, 2));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_stride();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return rand48();
            default: return 48'($urandom_range(64, 1));
        endcase
    endfunction

    // stride that packs cnt units of the previous level, sometimes with padding
    function automatic logic [DATA_W-1:0] grow(logic [DATA_W-1:0] prev,
                                               logic [DATA_W-1:0] cnt, bit first);
        logic [63:0] units;
        logic [63:0] wide;
        units = 64'(cnt) + (($urandom_range(3) == 0) ? 64'($urandom_range(4, 1)) : 64'd0);
        wide  = first ? units : 64'(prev) * units;
        return wide[DATA_W-1:0];
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // random descriptor: mostly packed or padded stride chains, some noise
    task automatic send_descriptor();
        int                shape;
        int                nlev;
        logic [DATA_W-1:0] s_prev;
        logic [DATA_W-1:0] d_prev;
        logic [DATA_W-1:0] cnt;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] d;
        shape  = $urandom_range(99);
        nlev   = ($urandom_range(19) == 0) ? $urandom_range(10, 8) : $urandom_range(7, 0);
        s_prev = '0;
        d_prev = '0;
        for (int k = 0; k < nlev; k++) begin
            cnt = pick_count();
            if (shape < 75) begin
                s = grow(s_prev, cnt, k == 0);
                d = grow(d_prev, cnt, k == 0);
            end else begin
                s = pick_stride();
                d = pick_stride();
            end
            send_item(level_item(s, d, cnt));
            s_prev = s;
            d_prev = d;
        end
        send_item(final_item(pick_count()));
    endtask

    // hold the sender until every expected verdict is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bare final counts, zero and full width
        send_item(final_item('0));
        send_item(final_item({DATA_W{1'b1}}));
        // packed single level
        send_item(level_item(48'd16, 48'd16, 48'd16));
        send_item(final_item(48'd5));
        // gap then unit final count, gap then larger final count
        send_item(level_item(48'd32, 48'd32, 48'd16));
        send_item(final_item(48'd1));
        send_item(level_item(48'd32, 48'd64, 48'd16));
        send_item(final_item(48'd3));
        // zero stride used as divisor
        send_item(level_item(48'd0, 48'd8, 48'd4));
        send_item(level_item(48'd8, 48'd8, 48'd1));
        send_item(final_item(48'd1));
        // product overflow, stays saturated after a zero count
        send_item(level_item({DATA_W{1'b1}}, {DATA_W{1'b1}}, {DATA_W{1'b1}}));
        send_item(level_item({DATA_W{1'b1}}, {DATA_W{1'b1}}, {DATA_W{1'b1}}));
        send_item(final_item('0));
        // one level past the limit, its count still multiplies in
        for (int k = 0; k < MAX_LEVELS; k++) send_item(level_item(48'd1, 48'd1, 48'd1));
        send_item(level_item(48'd1, 48'd1, 48'd3));
        send_item(final_item(48'd2));

        // light sender idling, heavy receiver stall
        while (items_sent < 430) send_descriptor();
        drain();
        send_idle_pct  = 71;
        recv_stall_pct = 6;
        while (items_sent < 840) send_descriptor();
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (items_sent < 1250) send_descriptor();

        // wait out the tail
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/stcc_pkg.sv
hdl/stcc_front.sv
hdl/stcc_queue.sv
hdl/stcc_arith.sv
hdl/stcc_back.sv
hdl/strided_transfer_contiguity_check_core.sv
verif/tb.sv
